// ===== rtl/keyed_table_compacting_delete_assert.svh =====
// assertion macros used by the checker file
// both sample on clock and are disabled while reset is high
`ifndef KEYED_TABLE_COMPACTING_DELETE_ASSERT_SVH
`define KEYED_TABLE_COMPACTING_DELETE_ASSERT_SVH

// same-cycle implication
`define KT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/kt_pkg.sv =====
// ----------------------------------------------------------------------------
// kt_pkg
// types and constants of the keyed table with compacting delete
// ----------------------------------------------------------------------------
package kt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int STEP_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(TABLE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

   // opcodes
   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_UPDATE = 3'd2;
   localparam logic [2:0] OP_SEARCH = 3'd3;
   localparam logic [2:0] OP_DUMP   = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_MISS  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] item_id;
      logic signed [31:0] quantity;
      logic [31:0]        price_bits;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_id;
      logic signed [31:0] out_quantity;
      logic [31:0]        out_price_bits;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] id;
      logic signed [31:0] quantity;
      logic [31:0]        price;
   } entry_type;

   // control from the sequencer to the cell row
   typedef struct packed {
      logic              rotate;
      logic              compact;
      logic [STEP_W-1:0] idx;
      entry_type         feed;
   } chain_ctrl_type;

endpackage

// ===== rtl/kt_cell.sv =====
// ----------------------------------------------------------------------------
// kt_cell
// one table slot: loads its neighbor's entry when told to shift
// ----------------------------------------------------------------------------
module kt_cell
   import kt_pkg::*;
(
   input  logic      clock,
   input  logic      shift,
   input  entry_type nbr_entry,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   assign entry_in = shift ? nbr_entry : entry_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/kt_chain.sv =====
// ----------------------------------------------------------------------------
// kt_chain
// row of table cells; rotates toward cell 0 or closes a gap above an index
// ----------------------------------------------------------------------------
module kt_chain
   import kt_pkg::*;
(
   input  logic           clock,
   input  chain_ctrl_type ctrl,
   output entry_type      head
);

   entry_type cell_q [TABLE_DEPTH];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type nbr;
      logic      shift;

      if (i == TABLE_DEPTH - 1) begin : g_tail
         // tail takes the feed on rotate and holds on compact
         assign nbr   = ctrl.feed;
         assign shift = ctrl.rotate;
      end else begin : g_body
         assign nbr   = cell_q[i+1];
         assign shift = ctrl.rotate || (ctrl.compact && (STEP_W'(i) >= ctrl.idx));
      end

      kt_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .nbr_entry (nbr),
         .entry     (cell_q[i])
      );
   end

   assign head = cell_q[0];

endmodule

// ===== rtl/keyed_table_compacting_delete.sv =====
// ----------------------------------------------------------------------------
// keyed_table_compacting_delete
// small keyed table in insertion order with first-match search and
// compacting delete
// ----------------------------------------------------------------------------
// The table lives in a row of TABLE_DEPTH cells that form a ring. Every
// command is one full revolution of the ring: each step moves every entry
// one cell toward cell 0, so the entries pass the head cell oldest first,
// and the entry leaving the head re-enters at the tail, or is replaced there
// by a new entry (add) or a new quantity (update). After TABLE_DEPTH steps
// the ring is back in place. A remove that hits adds a compact step in
// which the hit cell and the cells above it load from their upper neighbor.
// A step waits while a result is held in the output register by rsp_stall.
// req_stall is high for the whole command. Results go out through a
// one-item output register, so the next command is taken while the last
// result of the previous one still waits. Opcodes above dump are taken and
// give no result.
// ----------------------------------------------------------------------------
module keyed_table_compacting_delete
   import kt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   // command channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // result channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // sequencer states
   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_SCAN    = 2'd1;
   localparam logic [1:0] S_COMPACT = 2'd2;

   logic [1:0]         state_ff,   state_in;
   logic [STEP_W-1:0]  step_ff,    step_in;
   logic [COUNT_W-1:0] count_ff,   count_in;
   logic               found_ff,   found_in;
   logic [STEP_W-1:0]  hit_idx_ff, hit_idx_in;
   entry_type          hit_ff,     hit_in;
   req_type            cmd_ff,     cmd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff,     rsp_in;

   chain_ctrl_type ctrl;
   entry_type      head;

   logic out_free;
   logic head_used;
   logic match;
   logic found_next;
   logic final_step;
   logic [COUNT_W-1:0] step_ext;

   kt_chain u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .head  (head)
   );

   // a step may proceed only when the output register can take a result
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step_ext   = COUNT_W'(step_ff);
   // head cell holds entry number step while the ring turns
   assign head_used  = step_ext < count_ff;
   assign match      = head_used && (head.id == cmd_ff.item_id) && !found_ff;
   assign found_next = found_ff || match;
   assign final_step = step_ff == LAST_STEP;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_in       = hit_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      ctrl.rotate  = 1'b0;
      ctrl.compact = 1'b0;
      ctrl.idx     = hit_idx_ff;
      ctrl.feed    = head;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data;
               step_in  = '0;
               found_in = 1'b0;
               // unused opcodes are swallowed here
               if (req_data.opcode inside {[OP_ADD:OP_DUMP]}) begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (out_free) begin
               ctrl.rotate = 1'b1;
               step_in     = step_ff + STEP_W'(1);
               if (match) begin
                  found_in   = 1'b1;
                  hit_idx_in = step_ff;
                  hit_in     = head;
               end

               case (cmd_ff.opcode)
                  OP_ADD: begin
                     // first free slot passes the tail at step == count
                     if (step_ext == count_ff) begin
                        ctrl.feed.id       = cmd_ff.item_id;
                        ctrl.feed.quantity = cmd_ff.quantity;
                        ctrl.feed.price    = cmd_ff.price_bits;
                     end
                  end
                  OP_UPDATE: begin
                     if (match) begin
                        ctrl.feed.quantity = cmd_ff.quantity;
                     end
                  end
                  OP_DUMP: begin
                     if ((count_ff == '0) && (step_ff == '0)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '0;
                        rsp_in.status = ST_EMPTY;
                        rsp_in.last   = 1'b1;
                     end else if (head_used) begin
                        rsp_valid_in          = 1'b1;
                        rsp_in.status         = ST_OK;
                        rsp_in.out_id         = head.id;
                        rsp_in.out_quantity   = head.quantity;
                        rsp_in.out_price_bits = head.price;
                        rsp_in.last           = step_ext == (count_ff - COUNT_W'(1));
                     end
                  end
                  default: ;
               endcase

               if (final_step) begin
                  state_in = S_IDLE;
                  if (cmd_ff.opcode != OP_DUMP) begin
                     // single status result at the end of the revolution
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                     rsp_in.last  = 1'b1;
                     case (cmd_ff.opcode)
                        OP_ADD: begin
                           if (count_ff == FULL_COUNT) begin
                              rsp_in.status = ST_FULL;
                           end else begin
                              rsp_in.status = ST_OK;
                              count_in      = count_ff + COUNT_W'(1);
                           end
                        end
                        OP_REMOVE: begin
                           if (found_next) begin
                              rsp_in.status = ST_OK;
                              state_in      = S_COMPACT;
                           end else begin
                              rsp_in.status = ST_MISS;
                           end
                        end
                        OP_UPDATE: begin
                           rsp_in.status = found_next ? ST_OK : ST_MISS;
                        end
                        OP_SEARCH: begin
                           if (match) begin
                              rsp_in.status         = ST_OK;
                              rsp_in.out_id         = head.id;
                              rsp_in.out_quantity   = head.quantity;
                              rsp_in.out_price_bits = head.price;
                           end else if (found_ff) begin
                              rsp_in.status         = ST_OK;
                              rsp_in.out_id         = hit_ff.id;
                              rsp_in.out_quantity   = hit_ff.quantity;
                              rsp_in.out_price_bits = hit_ff.price;
                           end else begin
                              rsp_in.status = ST_MISS;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end

         S_COMPACT: begin
            // ring is back in place; close the gap left by the removed entry
            ctrl.compact = 1'b1;
            count_in     = count_ff - COUNT_W'(1);
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers, not reset; the command, step and found flag load at command accept
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      found_ff   <= found_in;
      hit_idx_ff <= hit_idx_in;
      hit_ff     <= hit_in;
      cmd_ff     <= cmd_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/kt_checker.sv =====
// ----------------------------------------------------------------------------
// kt_checker
// port-level checks of the keyed table, bound to the top level
// ----------------------------------------------------------------------------
`include "keyed_table_compacting_delete_assert.svh"

module kt_checker
   import kt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a waiting result stays and holds its payload
   `KT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")

   // a real command keeps the block busy for the next cycle
   `KT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall && (req_data.opcode <= OP_DUMP), req_stall, "block not busy after taking a command")

   // every error or empty status closes its command
   `KT_ASSERT_NOW(a_status_last, rsp_valid && (rsp_data.status != ST_OK), rsp_data.last, "non-ok result without last")

   // non-ok status results carry no entry
   `KT_ASSERT_NOW(a_status_zero, rsp_valid && (rsp_data.status != ST_OK), (rsp_data.out_id == 0) && (rsp_data.out_quantity == 0) && (rsp_data.out_price_bits == 0), "non-ok result carries entry fields")

endmodule

bind keyed_table_compacting_delete kt_checker u_kt_checker (.*);
